/* rtl/core/two_level_priority_task_queue_assert.svh */
// Assertion macros for the two-level priority task queue.
// No dependencies; included by the top level.
`ifndef TWO_LEVEL_PRIORITY_TASK_QUEUE_ASSERT_SVH
`define TWO_LEVEL_PRIORITY_TASK_QUEUE_ASSERT_SVH

`ifndef SYNTH
`define TLPQ_ASSERT(name, clk, rstn, prop) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("tlpq assertion failed");
`define TLPQ_ASSERT_NEXT(name, clk, rstn, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rstn) pre |=> post) \
        else $error("tlpq assertion failed");
`else
`define TLPQ_ASSERT(name, clk, rstn, prop)
`define TLPQ_ASSERT_NEXT(name, clk, rstn, pre, post)
`endif

`endif

/* rtl/core/tlpq_pkg.sv */
// Shared types and constants for the two-level priority task queue.
// No dependencies.
`default_nettype none

package tlpq_pkg;

    localparam int DEPTH      = 16;
    localparam int TASK_BYTES = 10;

    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int CAP_W   = 5;
    localparam int COUNT_W = 5;
    localparam int ACT_W   = 2;
    localparam int STAT_W  = 2;
    localparam int LOW_W   = 64;
    localparam int HIGH_W  = 16;

    localparam int S_FIELDS_W = ACT_W + LOW_W + HIGH_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = LOW_W + HIGH_W + 2 * COUNT_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_TUSER_W  = STAT_W + 1;

    localparam logic [LOW_W-1:0] TASK_LOW_MASK =
        (TASK_BYTES >= 8) ? {LOW_W{1'b1}} : ((LOW_W'(1) << (8 * TASK_BYTES)) - LOW_W'(1));
    localparam logic [HIGH_W-1:0] TASK_HIGH_MASK =
        (TASK_BYTES >= 10) ? 16'hFFFF : ((TASK_BYTES == 9) ? 16'h00FF : 16'h0000);

    typedef enum logic [ACT_W-1:0] {
        ACT_PUSH    = 2'd0,
        ACT_POP     = 2'd1,
        ACT_PROMOTE = 2'd2
    } tlpq_act_t;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_SKIP  = 2'd3
    } tlpq_status_t;

    typedef struct packed {
        logic [HIGH_W-1:0] high;
        logic [LOW_W-1:0]  low;
    } tlpq_task_t;

    // one bit per pointer; a set bit means the pointer sits in this cell
    typedef struct packed {
        logic n_head;
        logic n_tail;
        logic p_head;
        logic p_tail;
    } tlpq_tok_t;

    localparam int TOK_W = $bits(tlpq_tok_t);

    typedef struct packed {
        tlpq_tok_t  adv;
        tlpq_task_t wr;
    } tlpq_ctrl_t;

endpackage

`default_nettype wire

/* rtl/core/tlpq_cell.sv */
// One slot cell: normal and priority task entries plus the pointer tokens.
// Depends on tlpq_pkg.
`default_nettype none

module tlpq_cell (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [tlpq_pkg::IDX_W-1:0]  cell_idx,
    input  logic [tlpq_pkg::CNT_W-1:0]  cap_eff,
    input  tlpq_pkg::tlpq_ctrl_t        ctrl,
    input  tlpq_pkg::tlpq_tok_t         tok_in,
    output tlpq_pkg::tlpq_tok_t         tok_fwd,
    output tlpq_pkg::tlpq_tok_t         tok_wrap,
    output tlpq_pkg::tlpq_tok_t         tok_cur,
    output tlpq_pkg::tlpq_task_t        n_rd,
    output tlpq_pkg::tlpq_task_t        p_rd
);
    import tlpq_pkg::*;

    tlpq_tok_t  tok_reg;
    tlpq_tok_t  tok_next;
    tlpq_tok_t  last_mask;
    tlpq_task_t n_slot_reg;
    tlpq_task_t p_slot_reg;
    logic       last;

    // pointer wraps to cell 0 once it would reach the capacity
    assign last      = (CNT_W'(cell_idx) + CNT_W'(1)) >= cap_eff;
    assign last_mask = {TOK_W{last}};

    assign tok_fwd  = tok_reg & ctrl.adv & ~last_mask;
    assign tok_wrap = tok_reg & ctrl.adv & last_mask;
    assign tok_next = (tok_reg & ~ctrl.adv) | tok_in;
    assign tok_cur  = tok_reg;

    assign n_rd = tok_reg.n_head ? n_slot_reg : '0;
    assign p_rd = tok_reg.p_head ? p_slot_reg : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg <= (cell_idx == '0) ? {TOK_W{1'b1}} : '0;
        end else begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (tok_reg.n_tail && ctrl.adv.n_tail) begin
            n_slot_reg <= ctrl.wr;
        end
        if (tok_reg.p_tail && ctrl.adv.p_tail) begin
            p_slot_reg <= ctrl.wr;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/two_level_priority_task_queue.sv */
// Two-level priority task queue: one row of slot cells with token pointers,
// fill counters and a registered result beat. Depends on tlpq_pkg, tlpq_cell.
// Takes one operation beat per clock. Each push, pop or promote updates the slot
// cells and its fill counters in the cycle of its input beat, and the result beat
// appears on the m side in the next cycle; s_tready is low only while a result
// beat waits on a stalled m side. Each queue keeps tasks in a ring of up to
// capacity slots; a pointer moves as a token from cell to cell and wraps to
// cell 0 at the capacity. Capacity 0 acts as 1, values above 16 act as 16.
// Change capacity only while no operation is in flight.
`default_nettype none

`include "two_level_priority_task_queue_assert.svh"

module two_level_priority_task_queue (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [tlpq_pkg::CAP_W-1:0]       cfg_wr_data,   // capacity
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // action[1:0], task_low[65:2], task_high[81:66], zero pad
    input  logic [tlpq_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                             s_tuser,       // urgent
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // out_low[63:0], out_high[79:64], normal_count[84:80],
    // priority_count[89:85], zero pad
    output logic [tlpq_pkg::M_TDATA_W-1:0]   m_tdata,
    // status[1:0], from_priority[2]
    output logic [tlpq_pkg::M_TUSER_W-1:0]   m_tuser
);
    import tlpq_pkg::*;

    logic [CAP_W-1:0]     cap_reg;
    logic [CNT_W-1:0]     cap_eff;
    logic [CNT_W-1:0]     n_fill_reg, n_fill_next;
    logic [CNT_W-1:0]     p_fill_reg, p_fill_next;
    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [M_TUSER_W-1:0] m_tuser_reg, m_tuser_next;

    logic         s_fire;
    tlpq_act_t    act;
    tlpq_task_t   in_task;
    tlpq_ctrl_t   ctrl;
    tlpq_status_t status;
    logic         from_p;
    tlpq_task_t   out_task;

    tlpq_tok_t  tok_fwd  [DEPTH];
    tlpq_tok_t  tok_wrap [DEPTH];
    tlpq_tok_t  tok_cur  [DEPTH];
    tlpq_tok_t  tok_in   [DEPTH];
    tlpq_task_t n_rd     [DEPTH];
    tlpq_task_t p_rd     [DEPTH];
    tlpq_tok_t  wrap_any;
    tlpq_task_t n_head_task;
    tlpq_task_t p_head_task;
    logic [DEPTH-1:0] n_head_vec, n_tail_vec, p_head_vec, p_tail_vec;

    assign s_tready = !m_valid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    assign act          = tlpq_act_t'(s_tdata[ACT_W-1:0]);
    assign in_task.low  = s_tdata[ACT_W +: LOW_W] & TASK_LOW_MASK;
    assign in_task.high = s_tdata[ACT_W+LOW_W +: HIGH_W] & TASK_HIGH_MASK;

    always_comb begin
        if (cap_reg == '0) begin
            cap_eff = CNT_W'(1);
        end else if (int'(cap_reg) > DEPTH) begin
            cap_eff = CNT_W'(DEPTH);
        end else begin
            cap_eff = CNT_W'(cap_reg);
        end
    end

    generate
        for (genvar i = 0; i < DEPTH; i++) begin : g_cell
            if (i == 0) begin : g_first
                assign tok_in[i] = wrap_any;
            end else begin : g_rest
                assign tok_in[i] = tok_fwd[i-1];
            end

            tlpq_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .cell_idx (IDX_W'(i)),
                .cap_eff  (cap_eff),
                .ctrl     (ctrl),
                .tok_in   (tok_in[i]),
                .tok_fwd  (tok_fwd[i]),
                .tok_wrap (tok_wrap[i]),
                .tok_cur  (tok_cur[i]),
                .n_rd     (n_rd[i]),
                .p_rd     (p_rd[i])
            );

            assign n_head_vec[i] = tok_cur[i].n_head;
            assign n_tail_vec[i] = tok_cur[i].n_tail;
            assign p_head_vec[i] = tok_cur[i].p_head;
            assign p_tail_vec[i] = tok_cur[i].p_tail;
        end
    endgenerate

    always_comb begin
        wrap_any    = '0;
        n_head_task = '0;
        p_head_task = '0;
        for (int i = 0; i < DEPTH; i++) begin
            wrap_any    = wrap_any | tok_wrap[i];
            n_head_task = n_head_task | n_rd[i];
            p_head_task = p_head_task | p_rd[i];
        end
    end

    always_comb begin
        ctrl        = '0;
        status      = ST_DONE;
        from_p      = 1'b0;
        out_task    = '0;
        n_fill_next = n_fill_reg;
        p_fill_next = p_fill_reg;
        ctrl.wr     = (act == ACT_PROMOTE) ? n_head_task : in_task;
        case (act)
            ACT_PUSH: begin
                if (s_tuser) begin
                    if (p_fill_reg >= cap_eff) begin
                        status = ST_FULL;
                    end else begin
                        ctrl.adv.p_tail = 1'b1;
                        p_fill_next     = p_fill_reg + CNT_W'(1);
                    end
                end else begin
                    if (n_fill_reg >= cap_eff) begin
                        status = ST_FULL;
                    end else begin
                        ctrl.adv.n_tail = 1'b1;
                        n_fill_next     = n_fill_reg + CNT_W'(1);
                    end
                end
            end
            ACT_POP: begin
                if (p_fill_reg != '0) begin
                    ctrl.adv.p_head = 1'b1;
                    p_fill_next     = p_fill_reg - CNT_W'(1);
                    out_task        = p_head_task;
                    from_p          = 1'b1;
                end else if (n_fill_reg != '0) begin
                    ctrl.adv.n_head = 1'b1;
                    n_fill_next     = n_fill_reg - CNT_W'(1);
                    out_task        = n_head_task;
                end else begin
                    status = ST_EMPTY;
                end
            end
            ACT_PROMOTE: begin
                if (n_fill_reg == '0 || p_fill_reg >= cap_eff) begin
                    status = ST_SKIP;
                end else begin
                    ctrl.adv.n_head = 1'b1;
                    ctrl.adv.p_tail = 1'b1;
                    n_fill_next     = n_fill_reg - CNT_W'(1);
                    p_fill_next     = p_fill_reg + CNT_W'(1);
                end
            end
            default: begin
            end
        endcase
        if (!s_fire) begin
            ctrl.adv    = '0;
            n_fill_next = n_fill_reg;
            p_fill_next = p_fill_reg;
        end
    end

    assign m_tdata_next = M_TDATA_W'({COUNT_W'(p_fill_next), COUNT_W'(n_fill_next),
                                      out_task.high, out_task.low});
    assign m_tuser_next = {from_p, status};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg     <= CAP_W'(16);
            n_fill_reg  <= '0;
            p_fill_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
            n_fill_reg <= n_fill_next;
            p_fill_reg <= p_fill_next;
            if (s_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

    `TLPQ_ASSERT(a_fill_bound, aclk, aresetn, (n_fill_reg <= CNT_W'(DEPTH) && p_fill_reg <= CNT_W'(DEPTH)))
    `TLPQ_ASSERT(a_head_tok, aclk, aresetn, ($onehot(n_head_vec) && $onehot(p_head_vec)))
    `TLPQ_ASSERT(a_tail_tok, aclk, aresetn, ($onehot(n_tail_vec) && $onehot(p_tail_vec)))
    `TLPQ_ASSERT_NEXT(a_pop_prio, aclk, aresetn, (s_fire && act == ACT_POP && p_fill_reg != '0), (m_tuser[STAT_W] && m_tvalid))

endmodule

`default_nettype wire

/* dv/tb_two_level_priority_task_queue.sv */
// Self-checking testbench for two_level_priority_task_queue: directed and random
// push/pop/promote traffic over several capacities, checked by an in-bench predictor.
// Depends on tlpq_pkg and the two_level_priority_task_queue RTL.
`timescale 1ns / 1ps

module tb_two_level_priority_task_queue;
    import tlpq_pkg::*;

    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        tlpq_status_t         status;
        logic                 from_prio;
        logic [LOW_W-1:0]     low;
        logic [HIGH_W-1:0]    high;
        logic [COUNT_W-1:0]   n_cnt;
        logic [COUNT_W-1:0]   p_cnt;
    } queue_result_t;

    class queue_tracker;
        logic [LOW_W-1:0]  n_low [DEPTH];
        logic [HIGH_W-1:0] n_high [DEPTH];
        logic [LOW_W-1:0]  p_low [DEPTH];
        logic [HIGH_W-1:0] p_high [DEPTH];
        bit                n_written [DEPTH];
        bit                p_written [DEPTH];
        int unsigned       n_head, n_tail, p_head, p_tail, n_fill, p_fill;
        logic [CAP_W-1:0]  cap_reg;
        queue_result_t     due_results[$];
        int                errors, ops, settings;
        int                pushes, pops, promotes, fulls, empties, skips;

        function new();
            cap_reg = CAP_W'(16);
            for (int i = 0; i < DEPTH; i++) begin
                n_written[i] = 1'b0;
                p_written[i] = 1'b0;
            end
        endfunction

        function int unsigned slots();
            if (cap_reg == 0) return 1;
            if (cap_reg > DEPTH) return DEPTH;
            return cap_reg;
        endfunction

        function int unsigned step_ptr(int unsigned p);
            int unsigned n;
            n = p + 1;
            if (n >= slots() || n >= DEPTH) n = 0;
            return n;
        endfunction

        function void set_capacity(logic [CAP_W-1:0] v);
            cap_reg = v;
            settings++;
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        // true when the op would read a slot that has never been written
        function bit reads_unwritten(logic [ACT_W-1:0] act);
            if (act == ACT_POP) begin
                if (p_fill > 0) return !p_written[p_head];
                if (n_fill > 0) return !n_written[n_head];
            end else if (act == ACT_PROMOTE) begin
                if (n_fill > 0 && p_fill < slots()) return !n_written[n_head];
            end
            return 1'b0;
        endfunction

        function void apply_op(logic [ACT_W-1:0] act, logic urgent,
                               logic [LOW_W-1:0] lo, logic [HIGH_W-1:0] hi);
            queue_result_t exp;
            int unsigned   lim;
            exp = '0;
            exp.status = ST_DONE;
            lim = slots();
            lo &= TASK_LOW_MASK;
            hi &= TASK_HIGH_MASK;
            ops++;
            case (act)
                ACT_PUSH: begin
                    pushes++;
                    if (urgent) begin
                        if (p_fill >= lim) begin
                            exp.status = ST_FULL;
                        end else begin
                            p_low[p_tail] = lo;
                            p_high[p_tail] = hi;
                            p_written[p_tail] = 1'b1;
                            p_tail = step_ptr(p_tail);
                            p_fill++;
                        end
                    end else begin
                        if (n_fill >= lim) begin
                            exp.status = ST_FULL;
                        end else begin
                            n_low[n_tail] = lo;
                            n_high[n_tail] = hi;
                            n_written[n_tail] = 1'b1;
                            n_tail = step_ptr(n_tail);
                            n_fill++;
                        end
                    end
                end
                ACT_POP: begin
                    pops++;
                    if (p_fill > 0) begin
                        exp.low = p_low[p_head];
                        exp.high = p_high[p_head];
                        exp.from_prio = 1'b1;
                        p_head = step_ptr(p_head);
                        p_fill--;
                    end else if (n_fill > 0) begin
                        exp.low = n_low[n_head];
                        exp.high = n_high[n_head];
                        n_head = step_ptr(n_head);
                        n_fill--;
                    end else begin
                        exp.status = ST_EMPTY;
                    end
                end
                ACT_PROMOTE: begin
                    promotes++;
                    if (n_fill == 0 || p_fill >= lim) begin
                        exp.status = ST_SKIP;
                    end else begin
                        p_low[p_tail] = n_low[n_head];
                        p_high[p_tail] = n_high[n_head];
                        p_written[p_tail] = 1'b1;
                        n_head = step_ptr(n_head);
                        p_tail = step_ptr(p_tail);
                        n_fill--;
                        p_fill++;
                    end
                end
                default: ;
            endcase
            if (exp.status == ST_FULL) fulls++;
            if (exp.status == ST_EMPTY) empties++;
            if (exp.status == ST_SKIP) skips++;
            exp.n_cnt = COUNT_W'(n_fill);
            exp.p_cnt = COUNT_W'(p_fill);
            due_results.push_back(exp);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 100) $display("ERROR @%0t: %s", $time, msg);
        endtask

        task compare_result(queue_result_t got);
            queue_result_t exp;
            if (due_results.size() == 0) begin
                report("result beat with nothing expected");
                return;
            end
            exp = due_results.pop_front();
            if (got.status !== exp.status)
                report($sformatf("status %0d, expected %0d", got.status, exp.status));
            if (got.from_prio !== exp.from_prio)
                report($sformatf("from_priority %0b, expected %0b", got.from_prio,
                                 exp.from_prio));
            if (got.low !== exp.low)
                report($sformatf("out_low %h, expected %h", got.low, exp.low));
            if (got.high !== exp.high)
                report($sformatf("out_high %h, expected %h", got.high, exp.high));
            if (got.n_cnt !== exp.n_cnt)
                report($sformatf("normal_count %0d, expected %0d", got.n_cnt, exp.n_cnt));
            if (got.p_cnt !== exp.p_cnt)
                report($sformatf("priority_count %0d, expected %0d", got.p_cnt, exp.p_cnt));
        endtask

        task check_drained();
            if (due_results.size() != 0)
                report($sformatf("%0d results never arrived", due_results.size()));
        endtask
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [CAP_W-1:0]       cfg_wr_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [M_TUSER_W-1:0]   m_tuser;

    queue_tracker tracker;
    bit           idle_on;
    int           stall_left;

    two_level_priority_task_queue u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic int gap_cycles();
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [LOW_W-1:0] pick_low();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '1;
        if (r == 1) return '0;
        return {$urandom, $urandom};
    endfunction

    function automatic logic [HIGH_W-1:0] pick_high();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '1;
        if (r == 1) return '0;
        return HIGH_W'($urandom);
    endfunction

    // result side: random stalls while idling is on
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else if (idle_on && aresetn && $urandom_range(0, 99) < 20) begin
            m_tready <= 1'b0;
            stall_left = gap_cycles() - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            tracker.compare_result('{
                status:    tlpq_status_t'(m_tuser[STAT_W-1:0]),
                from_prio: m_tuser[STAT_W],
                low:       m_tdata[LOW_W-1:0],
                high:      m_tdata[LOW_W +: HIGH_W],
                n_cnt:     m_tdata[LOW_W+HIGH_W +: COUNT_W],
                p_cnt:     m_tdata[LOW_W+HIGH_W+COUNT_W +: COUNT_W]
            });
    end

    task automatic send_op(input logic [ACT_W-1:0] act, input logic urgent,
                           input logic [LOW_W-1:0] lo, input logic [HIGH_W-1:0] hi);
        int gap;
        gap = (idle_on && $urandom_range(0, 99) < 40) ? gap_cycles() : 0;
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - S_FIELDS_W){1'b0}}, hi, lo, act};
        s_tuser  <= urgent;
        do @(posedge aclk); while (!s_tready);
        tracker.apply_op(act, urgent, lo, hi);
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (tracker.pending() > 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] v);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        tracker.set_capacity(v);
    endtask

    task automatic run_phase(input logic [CAP_W-1:0] cap, input int n, input int push_pct,
                             input int pop_pct, input int promote_pct, input int urgent_pct,
                             input bit idle, input int hold_at);
        logic [ACT_W-1:0] act;
        int               r;
        wait_drained();
        write_capacity(cap);
        idle_on = idle;
        for (int i = 0; i < n; i++) begin
            if (i == hold_at) wait_drained();
            r = $urandom_range(0, 99);
            if (r < push_pct) act = ACT_PUSH;
            else if (r < push_pct + pop_pct) act = ACT_POP;
            else if (r < push_pct + pop_pct + promote_pct) act = ACT_PROMOTE;
            else act = ACT_UNUSED;
            if (tracker.reads_unwritten(act)) act = ACT_PUSH;
            send_op(act, $urandom_range(0, 99) < urgent_pct, pick_low(), pick_high());
        end
    endtask

    initial begin
        int waited;
        tracker     = new();
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = 1'b0;
        m_tready    = 1'b0;
        idle_on     = 1'b1;
        stall_left  = 0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // capacity 16 after reset: empty cases, extremes, promote, pop order
        send_op(ACT_POP, 1'b0, '0, '0);
        send_op(ACT_PROMOTE, 1'b0, '0, '0);
        send_op(ACT_UNUSED, 1'b1, '1, '1);
        send_op(ACT_PUSH, 1'b0, '1, '1);
        send_op(ACT_PUSH, 1'b0, '0, '0);
        send_op(ACT_PUSH, 1'b1, 64'h0123_4567_89AB_CDEF, 16'hFEDC);
        send_op(ACT_PROMOTE, 1'b0, '0, '0);
        send_op(ACT_POP, 1'b0, '0, '0);
        send_op(ACT_POP, 1'b0, '0, '0);
        send_op(ACT_POP, 1'b0, '0, '0);
        send_op(ACT_POP, 1'b0, '0, '0);

        // single slot: full on both queues, promote blocked by a full priority queue
        wait_drained();
        write_capacity(CAP_W'(1));
        send_op(ACT_PUSH, 1'b0, pick_low(), pick_high());
        send_op(ACT_PUSH, 1'b0, pick_low(), pick_high());
        send_op(ACT_PUSH, 1'b1, pick_low(), pick_high());
        send_op(ACT_PUSH, 1'b1, pick_low(), pick_high());
        send_op(ACT_PROMOTE, 1'b0, '0, '0);
        send_op(ACT_POP, 1'b0, '0, '0);
        send_op(ACT_PROMOTE, 1'b0, '0, '0);
        send_op(ACT_PROMOTE, 1'b0, '0, '0);
        send_op(ACT_POP, 1'b0, '0, '0);
        send_op(ACT_POP, 1'b0, '0, '0);

        // queues are left filled across phases so lowered capacities see waiting tasks
        run_phase(CAP_W'(16), 200, 65, 20, 12, 40, 1'b1, -1);
        run_phase(CAP_W'(2),  200, 30, 45, 22, 50, 1'b0, -1);
        run_phase(CAP_W'(0),  200, 45, 35, 17, 50, 1'b1, 100);
        run_phase(CAP_W'(31), 200, 60, 25, 12, 30, 1'b1, -1);
        run_phase(CAP_W'(5),  200, 40, 40, 17, 60, 1'b0, -1);
        run_phase(CAP_W'(17), 200, 50, 30, 17, 50, 1'b1, -1);
        run_phase(CAP_W'($urandom_range(1, 16)), 200, 35, 50, 12, 50, 1'b1, -1);

        @(negedge aclk);
        s_tvalid <= 1'b0;
        waited = 0;
        while (tracker.pending() > 0 && waited < 5000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (5) @(posedge aclk);
        tracker.check_drained();

        $display("Ran %0d operations across %0d capacity settings: %0d pushes, %0d pops, %0d promotes",
                 tracker.ops, tracker.settings, tracker.pushes, tracker.pops, tracker.promotes);
        $display("Saw %0d full pushes, %0d empty pops, %0d skipped promotes",
                 tracker.fulls, tracker.empties, tracker.skips);
        if (tracker.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/tlpq_pkg.sv
rtl/core/tlpq_cell.sv
rtl/core/two_level_priority_task_queue.sv
dv/tb_two_level_priority_task_queue.sv
